>>> src/memory_bus_test_sequencer_defines.svh
// assertion macros for the memory bus test sequencer
`ifndef MEMORY_BUS_TEST_SEQUENCER_DEFINES_SVH
`define MEMORY_BUS_TEST_SEQUENCER_DEFINES_SVH

// same-cycle implication
`define MBTS_ASSERT_IMP(label, ante, cons) \
  label: assert property (@(posedge clk_i) disable iff (!rst_ni) (ante) |-> cons) \
    else $error("mbts assertion failed");

// next-cycle implication
`define MBTS_ASSERT_NXT(label, ante, cons) \
  label: assert property (@(posedge clk_i) disable iff (!rst_ni) (ante) |=> cons) \
    else $error("mbts assertion failed");

`endif

>>> src/mbts_pkg.sv
// types and constants shared by the memory bus test sequencer files
`default_nettype none

package mbts_pkg;

  localparam int WORD_BITS = 32;
  localparam int DATA_BITS = (WORD_BITS < 32) ? WORD_BITS : 32;
  localparam logic [31:0] WORD_MASK = 32'((64'd1 << DATA_BITS) - 64'd1);
  localparam logic [5:0] DATA_BITS_W = 6'(DATA_BITS);

  localparam logic [31:0] WORD_PAT [4] = '{32'h5555_5555, 32'hAAAA_AAAA,
                                           32'h55AA_55AA, 32'hAA55_AA55};
  localparam logic [7:0] BYTE_PAT [4] = '{8'h55, 8'hAA, 8'h5A, 8'hA5};

  localparam logic [31:0] BASE_RESET  = 32'h8000_0000;
  localparam logic [32:0] SIZE_RESET  = 33'h0_2000_0000;
  localparam logic [5:0]  LINES_RESET = 6'd29;

  localparam logic REG_BASE_ADDRESS = 1'b0;
  localparam logic REG_BANK_SIZE    = 1'b1;

  typedef enum logic {
    OP_START = 1'b0,
    OP_READ  = 1'b1
  } op_e;

  typedef enum logic [2:0] {
    CMD_WRITE_WORD = 3'd0,
    CMD_WRITE_BYTE = 3'd1,
    CMD_READ_WORD  = 3'd2,
    CMD_READ_BYTE  = 3'd3,
    CMD_REPORT     = 3'd4
  } cmd_e;

  typedef enum logic [2:0] {
    PH_DATA   = 3'd0,
    PH_SINGLE = 3'd1,
    PH_PAIR   = 3'd2,
    PH_BYTES  = 3'd3,
    PH_IDLE   = 3'd4
  } phase_e;

  typedef enum logic [3:0] {
    TAIL_NONE,
    TAIL_DATA,
    TAIL_SINGLE,
    TAIL_PAIR,
    TAIL_BYTES,
    TAIL_FINISH,
    TAIL_READ_SINGLE,
    TAIL_READ_PAIR,
    TAIL_READ_BYTE
  } tail_e;

  typedef struct packed {
    op_e         operation;
    logic [31:0] read_data;
  } in_word_t;

  typedef struct packed {
    cmd_e        command;
    logic [31:0] address;
    logic [31:0] write_data;
    phase_e      phase;
    logic [4:0]  line_a;
    logic [4:0]  line_b;
    logic        mismatch;
    logic        bank_ok;
    logic        last;
  } out_word_t;

endpackage

`default_nettype wire

>>> src/memory_bus_test_sequencer.sv
// memory bus test sequencer top level
// an accepted item loads its results (up to six) into a result list;
// the first result moves from the list into the output register once that register is free
// one result leaves per cycle while out_stall_i does not hold the output; an item may have
// no result; the next item is taken as the last result moves out
// reset clears the control state, loads the register reset values, leaves it idle
`default_nettype none

module memory_bus_test_sequencer (
  input  wire logic               clk_i,
  input  wire logic               rst_ni,
  input  wire logic               in_valid_i,
  output logic                    in_stall_o,
  input  mbts_pkg::in_word_t      in_word_i,
  output logic                    out_valid_o,
  input  wire logic               out_stall_i,
  output mbts_pkg::out_word_t     out_word_o,
  input  wire logic               psel,
  input  wire logic               penable,
  input  wire logic               pwrite,
  input  wire logic [3:0]         paddr,
  input  wire logic [63:0]        pwdata,
  output logic [63:0]             prdata,
  output logic                    pready
);
  import mbts_pkg::*;

  logic [31:0] base_address_q;
  logic [32:0] bank_size_q;
  logic [5:0]  line_cfg_q;

  phase_e      phase_q, phase_d;
  logic [5:0]  line_count_q, line_count_d;
  logic [4:0]  first_index_q, first_index_d;
  logic [4:0]  second_index_q, second_index_d;
  logic [1:0]  read_slot_q, read_slot_d;
  logic        any_fail_q, any_fail_d;
  logic        phase_fail_q, phase_fail_d;

  out_word_t   list_q [6];
  out_word_t   list_d [6];
  logic [2:0]  cnt_q, cnt_d;
  out_word_t   out_q, out_d;
  logic        out_valid_q, out_valid_d;

  logic        take, out_free, move, acc, cfg_wr;
  logic        rep;
  out_word_t   rep_word;
  tail_e       tail;
  out_word_t   tail_w [6];
  logic [2:0]  tail_n;
  logic [31:0] rd_w;

  function automatic logic [31:0] line_off(logic [4:0] line);
    return 32'd1 << line;
  endfunction

  function automatic logic [31:0] pair_addr(logic [31:0] base, logic [4:0] fi,
                                            logic [4:0] si, logic [1:0] slot);
    logic [31:0] a;
    a = base;
    if (slot[0]) a = a + line_off(fi);
    if (slot[1]) a = a + line_off(si);
    return a;
  endfunction

  function automatic out_word_t mk(cmd_e c, logic [31:0] a, logic [31:0] d, phase_e p);
    out_word_t w;
    w = '0;
    w.command    = c;
    w.address    = a;
    w.write_data = d;
    w.phase      = p;
    return w;
  endfunction

  function automatic logic [5:0] lines_for(logic [32:0] size);
    logic [32:0] m1;
    logic [5:0]  n;
    m1 = size - 33'd1;
    n  = '0;
    if (size > 33'd1) begin
      for (int i = 0; i < 33; i++) begin
        if (m1[i]) n = 6'(i + 1);
      end
    end
    if (n > 6'd32) n = 6'd32;
    return n;
  endfunction

  // configuration port
  assign pready = 1'b1;
  assign cfg_wr = psel & penable & pwrite;
  assign prdata = paddr[3] ? {31'b0, bank_size_q} : {32'b0, base_address_q};

  always_ff @(posedge clk_i or negedge rst_ni) begin
    if (!rst_ni) begin
      base_address_q <= BASE_RESET;
      bank_size_q    <= SIZE_RESET;
      line_cfg_q     <= LINES_RESET;
    end else if (cfg_wr) begin
      unique case (paddr[3])
        REG_BASE_ADDRESS: base_address_q <= pwdata[31:0];
        REG_BANK_SIZE: begin
          bank_size_q <= pwdata[32:0];
          line_cfg_q  <= lines_for(pwdata[32:0]);
        end
        default: ;
      endcase
    end
  end

  // handshake
  assign take       = out_valid_q & ~out_stall_i;
  assign out_free   = ~out_valid_q | take;
  assign move       = (cnt_q != 3'd0) & out_free;
  assign in_stall_o = (cnt_q > 3'd1) | ((cnt_q == 3'd1) & ~out_free);
  assign acc        = in_valid_i & ~in_stall_o;
  assign rd_w       = in_word_i.read_data & WORD_MASK;

  // state update and choice of the words that follow
  always_comb begin
    phase_d        = phase_q;
    line_count_d   = line_count_q;
    first_index_d  = first_index_q;
    second_index_d = second_index_q;
    read_slot_d    = read_slot_q;
    any_fail_d     = any_fail_q;
    phase_fail_d   = phase_fail_q;
    rep            = 1'b0;
    rep_word       = mk(CMD_REPORT, base_address_q, 32'd0, phase_q);
    rep_word.mismatch = 1'b1;
    tail           = TAIL_NONE;
    if (acc) begin
      if (in_word_i.operation == OP_START) begin
        line_count_d   = line_cfg_q;
        any_fail_d     = 1'b0;
        phase_fail_d   = 1'b0;
        read_slot_d    = '0;
        second_index_d = '0;
        first_index_d  = '0;
        phase_d        = PH_DATA;
        tail           = TAIL_DATA;
      end else begin
        unique case (phase_q)
          PH_DATA: begin
            if (rd_w != (line_off(first_index_q) & WORD_MASK)) begin
              rep = 1'b1;
              rep_word.line_a = first_index_q;
              phase_fail_d = 1'b1;
              any_fail_d   = 1'b1;
            end
            if ({1'b0, first_index_q} + 6'd1 < DATA_BITS_W) begin
              first_index_d = first_index_q + 5'd1;
              tail = TAIL_DATA;
            end else if (phase_fail_d) begin
              tail = TAIL_FINISH;
            end else begin
              phase_fail_d = 1'b0;
              if (line_count_q >= 6'd4) begin
                first_index_d = 5'd2;
                tail = TAIL_SINGLE;
              end else begin
                tail = TAIL_BYTES;
              end
            end
          end
          PH_SINGLE: begin
            if (rd_w != ((read_slot_q[0] ? WORD_PAT[1] : WORD_PAT[0]) & WORD_MASK)) begin
              rep = 1'b1;
              rep_word.line_a = first_index_q;
              phase_fail_d = 1'b1;
              any_fail_d   = 1'b1;
            end
            if (read_slot_q == 2'd0) begin
              read_slot_d = 2'd1;
              tail = TAIL_READ_SINGLE;
            end else if ({1'b0, first_index_q} + 6'd2 < line_count_q) begin
              first_index_d = first_index_q + 5'd1;
              tail = TAIL_SINGLE;
            end else if (phase_fail_d) begin
              tail = TAIL_FINISH;
            end else begin
              phase_fail_d = 1'b0;
              if (line_count_q >= 6'd5) begin
                first_index_d  = 5'd2;
                second_index_d = 5'd3;
                tail = TAIL_PAIR;
              end else begin
                tail = TAIL_BYTES;
              end
            end
          end
          PH_PAIR: begin
            if (rd_w != (WORD_PAT[read_slot_q] & WORD_MASK)) begin
              rep = 1'b1;
              rep_word.line_a = first_index_q;
              rep_word.line_b = second_index_q;
              any_fail_d = 1'b1;
            end
            if (read_slot_q != 2'd3) begin
              read_slot_d = read_slot_q + 2'd1;
              tail = TAIL_READ_PAIR;
            end else if ({1'b0, second_index_q} + 6'd2 < line_count_q) begin
              second_index_d = second_index_q + 5'd1;
              tail = TAIL_PAIR;
            end else if ({1'b0, first_index_q} + 6'd3 < line_count_q) begin
              first_index_d  = first_index_q + 5'd1;
              second_index_d = first_index_q + 5'd2;
              tail = TAIL_PAIR;
            end else begin
              tail = TAIL_BYTES;
            end
          end
          PH_BYTES: begin
            if (in_word_i.read_data[7:0] != BYTE_PAT[read_slot_q]) begin
              rep = 1'b1;
              rep_word.line_b = 5'd1;
              any_fail_d = 1'b1;
              tail = TAIL_FINISH;
            end else if (read_slot_q != 2'd3) begin
              read_slot_d = read_slot_q + 2'd1;
              tail = TAIL_READ_BYTE;
            end else begin
              tail = TAIL_FINISH;
            end
          end
          default: ;
        endcase
      end
      unique case (tail)
        TAIL_SINGLE: begin
          phase_d     = PH_SINGLE;
          read_slot_d = '0;
        end
        TAIL_PAIR: begin
          phase_d     = PH_PAIR;
          read_slot_d = '0;
        end
        TAIL_BYTES: begin
          phase_d     = PH_BYTES;
          read_slot_d = '0;
        end
        TAIL_FINISH: phase_d = PH_IDLE;
        default: ;
      endcase
    end
  end

  // words issued after the optional report
  always_comb begin
    for (int i = 0; i < 6; i++) tail_w[i] = '0;
    tail_n = 3'd0;
    unique case (tail)
      TAIL_DATA: begin
        tail_w[0] = mk(CMD_WRITE_WORD, base_address_q, line_off(first_index_d) & WORD_MASK,
                       PH_DATA);
        tail_w[1] = mk(CMD_READ_WORD, base_address_q, 32'd0, PH_DATA);
        tail_n = 3'd2;
      end
      TAIL_SINGLE: begin
        tail_w[0] = mk(CMD_WRITE_WORD, base_address_q, WORD_PAT[0] & WORD_MASK, PH_SINGLE);
        tail_w[1] = mk(CMD_WRITE_WORD, base_address_q + line_off(first_index_d),
                       WORD_PAT[1] & WORD_MASK, PH_SINGLE);
        tail_w[2] = mk(CMD_READ_WORD, base_address_q, 32'd0, PH_SINGLE);
        tail_n = 3'd3;
      end
      TAIL_PAIR: begin
        for (int s = 0; s < 4; s++) begin
          tail_w[s] = mk(CMD_WRITE_WORD,
                         pair_addr(base_address_q, first_index_d, second_index_d, 2'(s)),
                         WORD_PAT[s] & WORD_MASK, PH_PAIR);
        end
        tail_w[4] = mk(CMD_READ_WORD, base_address_q, 32'd0, PH_PAIR);
        tail_n = 3'd5;
      end
      TAIL_BYTES: begin
        for (int s = 0; s < 4; s++) begin
          tail_w[s] = mk(CMD_WRITE_BYTE, base_address_q + 32'(s), {24'd0, BYTE_PAT[s]},
                         PH_BYTES);
        end
        tail_w[4] = mk(CMD_READ_BYTE, base_address_q, 32'd0, PH_BYTES);
        tail_n = 3'd5;
      end
      TAIL_FINISH: begin
        tail_w[0] = mk(CMD_REPORT, base_address_q, 32'd0, PH_IDLE);
        tail_w[0].bank_ok = ~any_fail_d;
        tail_w[0].last    = 1'b1;
        tail_n = 3'd1;
      end
      TAIL_READ_SINGLE: begin
        tail_w[0] = mk(CMD_READ_WORD, base_address_q + line_off(first_index_d), 32'd0,
                       PH_SINGLE);
        tail_n = 3'd1;
      end
      TAIL_READ_PAIR: begin
        tail_w[0] = mk(CMD_READ_WORD,
                       pair_addr(base_address_q, first_index_d, second_index_d, read_slot_d),
                       32'd0, PH_PAIR);
        tail_n = 3'd1;
      end
      TAIL_READ_BYTE: begin
        tail_w[0] = mk(CMD_READ_BYTE, base_address_q + {30'd0, read_slot_d}, 32'd0, PH_BYTES);
        tail_n = 3'd1;
      end
      default: ;
    endcase
  end

  // result list and output register
  always_comb begin
    for (int i = 0; i < 5; i++) list_d[i] = move ? list_q[i + 1] : list_q[i];
    list_d[5] = list_q[5];
    cnt_d     = move ? cnt_q - 3'd1 : cnt_q;
    if (acc) begin
      list_d[0] = rep ? rep_word : tail_w[0];
      for (int i = 1; i < 6; i++) list_d[i] = rep ? tail_w[i - 1] : tail_w[i];
      cnt_d = {2'b0, rep} + tail_n;
    end
    out_d       = move ? list_q[0] : out_q;
    out_valid_d = move | (out_valid_q & ~take);
  end

  always_ff @(posedge clk_i or negedge rst_ni) begin
    if (!rst_ni) begin
      phase_q        <= PH_IDLE;
      line_count_q   <= '0;
      first_index_q  <= '0;
      second_index_q <= '0;
      read_slot_q    <= '0;
      any_fail_q     <= 1'b0;
      phase_fail_q   <= 1'b0;
      cnt_q          <= '0;
      out_valid_q    <= 1'b0;
    end else begin
      phase_q        <= phase_d;
      line_count_q   <= line_count_d;
      first_index_q  <= first_index_d;
      second_index_q <= second_index_d;
      read_slot_q    <= read_slot_d;
      any_fail_q     <= any_fail_d;
      phase_fail_q   <= phase_fail_d;
      cnt_q          <= cnt_d;
      out_valid_q    <= out_valid_d;
    end
  end

  always_ff @(posedge clk_i) begin
    list_q <= list_d;
    out_q  <= out_d;
  end

  assign out_valid_o = out_valid_q;
  assign out_word_o  = out_q;

endmodule

`default_nettype wire

>>> src/mbts_checker.sv
// port checker for the memory bus test sequencer and its bind
`default_nettype none
`include "memory_bus_test_sequencer_defines.svh"

module mbts_checker (
  input wire logic                clk_i,
  input wire logic                rst_ni,
  input wire logic                in_valid_i,
  input wire logic                in_stall_o,
  input wire mbts_pkg::in_word_t  in_word_i,
  input wire logic                out_valid_o,
  input wire logic                out_stall_i,
  input wire mbts_pkg::out_word_t out_word_o,
  input wire logic                psel,
  input wire logic                penable,
  input wire logic                pwrite,
  input wire logic [3:0]          paddr,
  input wire logic [63:0]         pwdata,
  input wire logic [63:0]         prdata,
  input wire logic                pready
);
  import mbts_pkg::*;

  logic start_acc;
  assign start_acc = in_valid_i && !in_stall_o && (in_word_i.operation == OP_START);

  `MBTS_ASSERT_NXT(a_out_hold, out_valid_o && out_stall_i, out_valid_o && $stable(out_word_o))
  `MBTS_ASSERT_NXT(a_start_stalls, start_acc, in_stall_o)
  `MBTS_ASSERT_IMP(a_start_output, start_acc, ##2 out_valid_o)
  `MBTS_ASSERT_IMP(a_last_report, out_valid_o && out_word_o.last, out_word_o.command == CMD_REPORT && out_word_o.phase == PH_IDLE && !out_word_o.mismatch)

endmodule

bind memory_bus_test_sequencer mbts_checker u_mbts_checker (.*);

`default_nettype wire

>>> verif/memory_bus_test_sequencer_tb.sv
// self-checking testbench for the memory bus test sequencer, with a memory model answering reads
`default_nettype none

module testbench;
  timeunit 1ns;
  timeprecision 1ps;

  import mbts_pkg::*;

  localparam logic [31:0] WORD_PATTERNS [4] = '{32'h5555_5555, 32'hAAAA_AAAA,
                                                32'h55AA_55AA, 32'hAA55_AA55};
  localparam logic [7:0] BYTE_PATTERNS [4] = '{8'h55, 8'hAA, 8'h5A, 8'hA5};
  localparam int SETTING_QUOTA = 30;

  logic        clk_i = 1'b0;
  logic        rst_ni = 1'b0;
  logic        in_valid_i = 1'b0;
  logic        in_stall_o;
  in_word_t    in_word_i = '0;
  logic        out_valid_o;
  logic        out_stall_i = 1'b0;
  out_word_t   out_word_o;
  logic        psel = 1'b0;
  logic        penable = 1'b0;
  logic        pwrite = 1'b0;
  logic [3:0]  paddr = '0;
  logic [63:0] pwdata = '0;
  logic [63:0] prdata;
  logic        pready;

  memory_bus_test_sequencer i_dut (
    .clk_i       (clk_i),
    .rst_ni      (rst_ni),
    .in_valid_i  (in_valid_i),
    .in_stall_o  (in_stall_o),
    .in_word_i   (in_word_i),
    .out_valid_o (out_valid_o),
    .out_stall_i (out_stall_i),
    .out_word_o  (out_word_o),
    .psel        (psel),
    .penable     (penable),
    .pwrite      (pwrite),
    .paddr       (paddr),
    .pwdata      (pwdata),
    .prdata      (prdata),
    .pready      (pready)
  );

  always begin
    #5 clk_i = 1'b1;
    #5 clk_i = 1'b0;
  end

  // sequencer state as predicted
  logic [31:0] cfg_base = 32'h8000_0000;
  logic [32:0] cfg_size = 33'h0_2000_0000;
  phase_e      bank_phase = PH_IDLE;
  logic [5:0]  addr_lines = '0;
  logic [4:0]  line_i = '0;
  logic [4:0]  line_j = '0;
  logic [1:0]  read_step = '0;
  logic        bank_failed = 1'b0;
  logic        phase_failed = 1'b0;

  out_word_t   due_commands [$];
  in_word_t    bank_inputs [$];
  logic [7:0]  mem_image [logic [31:0]];
  logic [31:0] read_addr = '0;
  logic        read_byte = 1'b0;

  phase_e      fail_phase = PH_IDLE;
  logic [4:0]  fail_line = '0;
  int          fault_pct = 0;
  int          items_done = 0;
  int          issued_count = 0;
  int          taken_count = 0;
  int          mismatch_count = 0;
  int          hold_requests = 0;
  int          holds_served = 0;
  int          hold_left = 0;
  int          rx_gap = 0;
  int          rx_quiet = 0;
  int          tx_gap = 0;
  int          tx_quiet = 0;
  logic        calm = 1'b0;
  logic        offer_done = 1'b0;
  out_word_t   head_word;

  function automatic logic [5:0] lines_for(logic [32:0] size);
    int n;
    n = 0;
    while (n < 32 && (33'd1 << n) < size) n++;
    return 6'(n);
  endfunction

  function automatic logic [31:0] line_bit(logic [4:0] line);
    return 32'd1 << line;
  endfunction

  function automatic logic [31:0] pair_address(logic [1:0] slot);
    logic [31:0] a;
    a = cfg_base;
    if (slot[0]) a += line_bit(line_i);
    if (slot[1]) a += line_bit(line_j);
    return a;
  endfunction

  task automatic add_access(cmd_e cmd, logic [31:0] addr, logic [31:0] data, phase_e ph);
    out_word_t w;
    w = '0;
    w.command = cmd;
    w.address = addr;
    w.write_data = data;
    w.phase = ph;
    due_commands.push_back(w);
    case (cmd)
      CMD_WRITE_WORD: begin
        for (int b = 0; b < 4; b++) mem_image[addr + 32'(b)] = data[8*b +: 8];
      end
      CMD_WRITE_BYTE: mem_image[addr] = data[7:0];
      default: begin
        read_addr = addr;
        read_byte = (cmd == CMD_READ_BYTE);
      end
    endcase
  endtask

  task automatic add_report(phase_e ph, logic [4:0] la, logic [4:0] lb, logic mm, logic ok,
                            logic fin);
    out_word_t w;
    w = '0;
    w.command = CMD_REPORT;
    w.address = cfg_base;
    w.phase = ph;
    w.line_a = la;
    w.line_b = lb;
    w.mismatch = mm;
    w.bank_ok = ok;
    w.last = fin;
    due_commands.push_back(w);
  endtask

  task automatic open_data();
    add_access(CMD_WRITE_WORD, cfg_base, line_bit(line_i) & WORD_MASK, PH_DATA);
    add_access(CMD_READ_WORD, cfg_base, '0, PH_DATA);
  endtask

  task automatic open_single();
    bank_phase = PH_SINGLE;
    read_step = '0;
    add_access(CMD_WRITE_WORD, cfg_base, WORD_PATTERNS[0] & WORD_MASK, PH_SINGLE);
    add_access(CMD_WRITE_WORD, cfg_base + line_bit(line_i), WORD_PATTERNS[1] & WORD_MASK,
               PH_SINGLE);
    add_access(CMD_READ_WORD, cfg_base, '0, PH_SINGLE);
  endtask

  task automatic open_pair();
    bank_phase = PH_PAIR;
    read_step = '0;
    for (int s = 0; s < 4; s++) begin
      add_access(CMD_WRITE_WORD, pair_address(2'(s)), WORD_PATTERNS[s] & WORD_MASK, PH_PAIR);
    end
    add_access(CMD_READ_WORD, pair_address(2'd0), '0, PH_PAIR);
  endtask

  task automatic open_bytes();
    bank_phase = PH_BYTES;
    read_step = '0;
    for (int s = 0; s < 4; s++) begin
      add_access(CMD_WRITE_BYTE, cfg_base + 32'(s), 32'(BYTE_PATTERNS[s]), PH_BYTES);
    end
    add_access(CMD_READ_BYTE, cfg_base, '0, PH_BYTES);
  endtask

  task automatic close_bank();
    bank_phase = PH_IDLE;
    add_report(PH_IDLE, '0, '0, 1'b0, !bank_failed, 1'b1);
  endtask

  task automatic enter_pairs();
    phase_failed = 1'b0;
    if (addr_lines >= 6'd5) begin
      line_i = 5'd2;
      line_j = 5'd3;
      open_pair();
    end else begin
      open_bytes();
    end
  endtask

  task automatic sequence_bank_item(in_word_t w);
    logic [31:0] rd;
    rd = w.read_data;
    if (w.operation == OP_START) begin
      addr_lines = lines_for(cfg_size);
      bank_failed = 1'b0;
      phase_failed = 1'b0;
      read_step = '0;
      line_j = '0;
      line_i = '0;
      bank_phase = PH_DATA;
      mem_image.delete();
      open_data();
    end else begin
      case (bank_phase)
        PH_DATA: begin
          if ((rd & WORD_MASK) != (line_bit(line_i) & WORD_MASK)) begin
            add_report(PH_DATA, line_i, '0, 1'b1, 1'b0, 1'b0);
            phase_failed = 1'b1;
            bank_failed = 1'b1;
          end
          if (int'(line_i) + 1 < DATA_BITS) begin
            line_i++;
            open_data();
          end else if (phase_failed) begin
            close_bank();
          end else begin
            phase_failed = 1'b0;
            if (addr_lines >= 6'd4) begin
              line_i = 5'd2;
              open_single();
            end else begin
              enter_pairs();
            end
          end
        end
        PH_SINGLE: begin
          if ((rd & WORD_MASK) != (WORD_PATTERNS[read_step[0]] & WORD_MASK)) begin
            add_report(PH_SINGLE, line_i, '0, 1'b1, 1'b0, 1'b0);
            phase_failed = 1'b1;
            bank_failed = 1'b1;
          end
          if (read_step == 2'd0) begin
            read_step = 2'd1;
            add_access(CMD_READ_WORD, cfg_base + line_bit(line_i), '0, PH_SINGLE);
          end else if (int'(line_i) + 2 < int'(addr_lines)) begin
            line_i++;
            open_single();
          end else if (phase_failed) begin
            close_bank();
          end else begin
            enter_pairs();
          end
        end
        PH_PAIR: begin
          if ((rd & WORD_MASK) != (WORD_PATTERNS[read_step] & WORD_MASK)) begin
            add_report(PH_PAIR, line_i, line_j, 1'b1, 1'b0, 1'b0);
            bank_failed = 1'b1;
          end
          if (read_step < 2'd3) begin
            read_step++;
            add_access(CMD_READ_WORD, pair_address(read_step), '0, PH_PAIR);
          end else if (int'(line_j) + 2 < int'(addr_lines)) begin
            line_j++;
            open_pair();
          end else if (int'(line_i) + 3 < int'(addr_lines)) begin
            line_i++;
            line_j = line_i + 5'd1;
            open_pair();
          end else begin
            open_bytes();
          end
        end
        PH_BYTES: begin
          if (rd[7:0] != BYTE_PATTERNS[read_step]) begin
            add_report(PH_BYTES, '0, 5'd1, 1'b1, 1'b0, 1'b0);
            bank_failed = 1'b1;
            close_bank();
          end else if (read_step < 2'd3) begin
            read_step++;
            add_access(CMD_READ_BYTE, cfg_base + 32'(read_step), '0, PH_BYTES);
          end else begin
            close_bank();
          end
        end
        default: ;
      endcase
    end
  endtask

  // memory contents for the outstanding read, with an occasional injected bit error
  function automatic logic [31:0] reply_data();
    logic [31:0] v;
    logic        corrupt;
    v = $urandom;
    for (int b = 0; b < 4; b++) begin
      if ((b == 0 || !read_byte) && mem_image.exists(read_addr + 32'(b))) begin
        v[8*b +: 8] = mem_image[read_addr + 32'(b)];
      end
    end
    corrupt = ($urandom_range(99, 0) < fault_pct) ||
              (bank_phase == fail_phase && line_i == fail_line && read_step == 2'd0);
    if (corrupt) v ^= read_byte ? 32'd1 << $urandom_range(7, 0) : 32'd1 << $urandom_range(31, 0);
    return v;
  endfunction

  // long banks are cut short by a forced data or single-line failure
  task automatic plan_faults();
    logic [5:0] n;
    n = lines_for(cfg_size);
    fail_phase = PH_IDLE;
    fault_pct = 0;
    if (n > 6'd9) begin
      if ($urandom_range(1, 0) == 1) begin
        fail_phase = PH_SINGLE;
        fail_line = 5'($urandom_range(int'(n) - 2, 2));
      end else begin
        fail_phase = PH_DATA;
        fail_line = 5'($urandom_range(31, 0));
      end
    end else begin
      case ($urandom_range(4, 0))
        0: fault_pct = 15;
        1: fault_pct = 3;
        default: ;
      endcase
    end
  endtask

  task automatic offer_word(op_e op, logic [31:0] data);
    in_word_t w;
    w.operation = op;
    w.read_data = data;
    bank_inputs.push_back(w);
    issued_count++;
    wait (taken_count == issued_count);
  endtask

  task automatic feed_one();
    if (bank_phase == PH_IDLE || $urandom_range(99, 0) == 0) begin
      if (bank_phase == PH_IDLE && $urandom_range(7, 0) == 0) offer_word(OP_READ, $urandom);
      plan_faults();
      offer_word(OP_START, $urandom);
    end else begin
      offer_word(OP_READ, reply_data());
    end
    items_done++;
  endtask

  task automatic write_register(logic reg_sel, logic [63:0] value);
    @(negedge clk_i);
    psel <= 1'b1;
    penable <= 1'b0;
    pwrite <= 1'b1;
    paddr <= {reg_sel, 3'b000};
    pwdata <= value;
    @(negedge clk_i);
    penable <= 1'b1;
    @(negedge clk_i);
    psel <= 1'b0;
    penable <= 1'b0;
    pwrite <= 1'b0;
    if (reg_sel == REG_BASE_ADDRESS) cfg_base = value[31:0];
    else cfg_size = value[32:0];
  endtask

  function automatic int pick_gap(inout int quiet);
    if (quiet > 0) begin
      quiet--;
      return 0;
    end
    if ($urandom_range(15, 0) == 0) begin
      quiet = $urandom_range(80, 20);
      return 0;
    end
    return ($urandom_range(4, 0) == 0) ? int'($urandom_range(13, 1)) : 0;
  endfunction

  always @(posedge clk_i) begin
    if (rst_ni && in_valid_i && !in_stall_o) begin
      sequence_bank_item(in_word_i);
      offer_done = 1'b1;
      taken_count++;
    end
  end

  always @(negedge clk_i) begin
    if (rst_ni && (!in_valid_i || offer_done)) begin
      if (offer_done && !calm) tx_gap = pick_gap(tx_quiet);
      offer_done = 1'b0;
      if (tx_gap > 0) begin
        tx_gap--;
        in_valid_i <= 1'b0;
      end else if (bank_inputs.size() != 0) begin
        in_word_i <= bank_inputs.pop_front();
        in_valid_i <= 1'b1;
      end else begin
        in_valid_i <= 1'b0;
      end
    end
  end

  always @(negedge clk_i) begin
    if (holds_served != hold_requests) begin
      holds_served = hold_requests;
      hold_left = 300;
    end
    if (hold_left > 0) begin
      hold_left--;
      out_stall_i <= 1'b1;
    end else if (rx_gap > 0) begin
      rx_gap--;
      out_stall_i <= 1'b1;
    end else if (calm) begin
      out_stall_i <= 1'b0;
    end else begin
      rx_gap = pick_gap(rx_quiet);
      out_stall_i <= (rx_gap > 0);
      if (rx_gap > 0) rx_gap--;
    end
  end

  task automatic check_field(string name, logic [31:0] want, logic [31:0] got);
    if (want !== got) begin
      $error("%s: expected %0h, actual %0h", name, want, got);
      mismatch_count++;
    end
  endtask

  always @(posedge clk_i) begin
    if (rst_ni && out_valid_o && !out_stall_i) begin
      if (due_commands.size() == 0) begin
        $error("unexpected word: %p", out_word_o);
        mismatch_count++;
      end else begin
        head_word = due_commands.pop_front();
        check_field("command", 32'(head_word.command), 32'(out_word_o.command));
        check_field("address", head_word.address, out_word_o.address);
        check_field("write_data", head_word.write_data, out_word_o.write_data);
        check_field("phase", 32'(head_word.phase), 32'(out_word_o.phase));
        check_field("line_a", 32'(head_word.line_a), 32'(out_word_o.line_a));
        check_field("line_b", 32'(head_word.line_b), 32'(out_word_o.line_b));
        check_field("mismatch", 32'(head_word.mismatch), 32'(out_word_o.mismatch));
        check_field("bank_ok", 32'(head_word.bank_ok), 32'(out_word_o.bank_ok));
        check_field("last", 32'(head_word.last), 32'(out_word_o.last));
      end
    end
  end

  initial begin
    logic [31:0] base_sel;
    logic [32:0] size_sel;
    repeat (3) @(posedge clk_i);
    @(negedge clk_i);
    rst_ni <= 1'b1;
    for (int s = 0; s < 9; s++) begin
      base_sel = $urandom;
      case (s)
        0: begin
          base_sel = 32'hFFFF_FFFF;
          size_sel = 33'h1_0000_0000;
        end
        1: begin
          base_sel = '0;
          size_sel = 33'd1;
        end
        2: size_sel = 33'd2;
        3: size_sel = 33'($urandom_range(8, 3));
        4: size_sel = 33'($urandom_range(16, 9));
        5: size_sel = 33'($urandom_range(32, 17));
        6: size_sel = 33'($urandom_range(256, 33));
        7: size_sel = 33'($urandom_range(32'hFFFF_FFFF, 1));
        default: size_sel = 33'($urandom_range(64, 1));
      endcase
      if (s > 0) begin
        while (due_commands.size() != 0) @(posedge clk_i);
        repeat (10) @(posedge clk_i);
      end
      if (s == 8) calm = 1'b1;
      write_register(REG_BASE_ADDRESS, 64'(base_sel));
      write_register(REG_BANK_SIZE, 64'(size_sel));
      if (s == 0) begin
        // ignored reads, extreme read data and a restart of a running bank
        offer_word(OP_READ, 32'h0);
        offer_word(OP_READ, 32'hFFFF_FFFF);
        plan_faults();
        offer_word(OP_START, 32'hFFFF_FFFF);
        offer_word(OP_READ, reply_data());
        offer_word(OP_READ, 32'h0);
        offer_word(OP_READ, 32'hFFFF_FFFF);
        repeat (3) offer_word(OP_READ, reply_data());
        plan_faults();
        offer_word(OP_START, 32'h0);
        items_done += 8;
      end
      if (s == 3) hold_requests++;
      items_done = (s == 0) ? items_done : 0;
      while (items_done < SETTING_QUOTA || bank_phase != PH_IDLE) feed_one();
      items_done = 0;
    end
    while (due_commands.size() != 0) @(posedge clk_i);
    repeat (20) @(posedge clk_i);
    if (mismatch_count == 0) begin
      $display("No mismatches found");
    end else begin
      $display("Mismatches found");
    end
    $finish;
  end

  initial begin
    #5_000_000;
    $display("Mismatches found");
    $finish;
  end

endmodule

`default_nettype wire
